// ===== hdl/mktd_pkg.sv =====
// Shared types, constants and the letter lookup for the Morse key timing decoder.
// Used by every module under hdl; depends on nothing else.
package mktd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int CODE_W      = 8;
    localparam int CHAR_W      = 7;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'd32;
    localparam logic [CHAR_W-1:0] CH_INVALID = 7'd35;
    localparam logic [CHAR_W-1:0] CH_A       = 7'd65;

    localparam logic [1:0] SYM_DOT  = 2'b01;
    localparam logic [1:0] SYM_DASH = 2'b10;

    localparam logic [CFG_W-1:0] DASH_MIN_RESET  = 16'd500;
    localparam logic [CFG_W-1:0] SPACE_GAP_RESET = 16'd1250;

    // configuration register indexes
    localparam logic REG_DASH_MIN  = 1'b0;
    localparam logic REG_SPACE_GAP = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] dash_min;
        logic [CFG_W-1:0] space_gap;
    } cfg_t;

    // one queued action: a letter, a space, or a letter followed by a space
    typedef struct packed {
        logic              has_letter;
        logic [CODE_W-1:0] code;
        logic              has_space;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              inv;
    } lookup_t;

    function automatic lookup_t letter_lookup(input logic [CODE_W-1:0] code);
        lookup_t    r;
        logic [4:0] idx;
        logic       hit;
        idx = '0;
        hit = 1'b1;
        unique case (code)
            8'h60: idx = 5'd0;
            8'h95: idx = 5'd1;
            8'h99: idx = 5'd2;
            8'h94: idx = 5'd3;
            8'h40: idx = 5'd4;
            8'h59: idx = 5'd5;
            8'hA4: idx = 5'd6;
            8'h55: idx = 5'd7;
            8'h50: idx = 5'd8;
            8'h6A: idx = 5'd9;
            8'h98: idx = 5'd10;
            8'h65: idx = 5'd11;
            8'hA0: idx = 5'd12;
            8'h90: idx = 5'd13;
            8'hA8: idx = 5'd14;
            8'h69: idx = 5'd15;
            8'hA6: idx = 5'd16;
            8'h64: idx = 5'd17;
            8'h54: idx = 5'd18;
            8'h80: idx = 5'd19;
            8'h58: idx = 5'd20;
            8'h56: idx = 5'd21;
            8'h68: idx = 5'd22;
            8'h96: idx = 5'd23;
            8'h9A: idx = 5'd24;
            8'hA5: idx = 5'd25;
            default: hit = 1'b0;
        endcase
        r.ch  = hit ? CH_A + CHAR_W'(idx) : CH_INVALID;
        r.inv = !hit;
        return r;
    endfunction

endpackage

// ===== hdl/mktd_front.sv =====
// Front end: accepts key ticks, tracks edges and timing, builds the symbol code
// and pushes letter/space actions into the queue. Depends on mktd_pkg.
module mktd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mktd_pkg::cfg_t        cfg,
    input  logic                  accept,
    input  logic                  key_level,
    output logic                  push,
    output mktd_pkg::entry_t      push_entry
);
    import mktd_pkg::*;

    logic                   prev_level_reg, prev_level_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic [1:0]             sym_count_reg, sym_count_next;

    logic [COUNT_WIDTH-1:0] cnt;
    logic [CMP_W-1:0]       cnt_ext, dash_ext, word_ext;
    logic [1:0]             sym;
    logic [CODE_W-1:0]      code_with_sym;

    assign cnt      = (elapsed_reg == COUNT_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign cnt_ext  = CMP_W'(cnt);
    assign dash_ext = CMP_W'(cfg.dash_min);
    assign word_ext = CMP_W'(cfg.space_gap);
    assign sym      = (cnt_ext >= dash_ext) ? SYM_DASH : SYM_DOT;

    always_comb
    begin
        code_with_sym = code_reg;
        unique case (sym_count_reg)
            2'd0: code_with_sym[7:6] = sym;
            2'd1: code_with_sym[5:4] = sym;
            2'd2: code_with_sym[3:2] = sym;
            2'd3: code_with_sym[1:0] = sym;
        endcase
    end

    always_comb
    begin
        prev_level_next       = prev_level_reg;
        elapsed_next          = elapsed_reg;
        code_next             = code_reg;
        sym_count_next        = sym_count_reg;
        push                  = 1'b0;
        push_entry.has_letter = 1'b0;
        push_entry.code       = code_reg;
        push_entry.has_space  = 1'b0;
        if (accept)
        begin
            prev_level_next = key_level;
            priority if (prev_level_reg && !key_level)
            begin
                // release: record the symbol, flush on the fourth
                elapsed_next = '0;
                if (sym_count_reg == 2'd3)
                begin
                    push                  = 1'b1;
                    push_entry.has_letter = 1'b1;
                    push_entry.code       = code_with_sym;
                    code_next             = '0;
                    sym_count_next        = '0;
                end
                else
                begin
                    code_next      = code_with_sym;
                    sym_count_next = sym_count_reg + 2'd1;
                end
            end
            else if (!prev_level_reg && key_level)
            begin
                // press after a letter gap ends the letter
                elapsed_next = '0;
                if (cnt_ext >= dash_ext && cnt_ext < word_ext && sym_count_reg != 2'd0)
                begin
                    push                  = 1'b1;
                    push_entry.has_letter = 1'b1;
                    code_next             = '0;
                    sym_count_next        = '0;
                end
            end
            else
            begin
                elapsed_next = cnt;
                // word space fires once, never while the count sits saturated
                if (!key_level && cnt_ext == word_ext && cnt != elapsed_reg)
                begin
                    push                  = 1'b1;
                    push_entry.has_letter = (sym_count_reg != 2'd0);
                    push_entry.has_space  = 1'b1;
                    code_next             = '0;
                    sym_count_next        = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            elapsed_reg    <= '0;
            code_reg       <= '0;
            sym_count_reg  <= '0;
        end
        else
        begin
            prev_level_reg <= prev_level_next;
            elapsed_reg    <= elapsed_next;
            code_reg       <= code_next;
            sym_count_reg  <= sym_count_next;
        end
    end

endmodule

// ===== hdl/mktd_fifo.sv =====
// Action queue between front and back end, FIFO_DEPTH entries of entry_t.
// Depends on mktd_pkg.
module mktd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mktd_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              full,
    output mktd_pkg::head_t   head
);
    import mktd_pkg::*;

    entry_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue pop while empty");

endmodule

// ===== hdl/mktd_back.sv =====
// Back end: pops queued actions, looks up the letter and drives the output
// register, splitting a letter-then-space action over two transfers. Depends on mktd_pkg.
module mktd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mktd_pkg::head_t               head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mktd_pkg::CHAR_W-1:0]   char_code,
    output logic                          is_invalid,
    output logic                          last_of_run
);
    import mktd_pkg::*;

    logic              valid_reg, valid_next;
    logic              space_pend_reg, space_pend_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              inv_reg, inv_next;
    logic              last_reg, last_next;
    logic              load;
    lookup_t           lk;

    assign lk   = letter_lookup(head.entry.code);
    assign load = !valid_reg || !out_stall;
    assign pop  = load && !space_pend_reg && head.valid;

    always_comb
    begin
        valid_next      = valid_reg;
        space_pend_next = space_pend_reg;
        char_next       = char_reg;
        inv_next        = inv_reg;
        last_next       = last_reg;
        if (load)
        begin
            priority if (space_pend_reg)
            begin
                valid_next      = 1'b1;
                space_pend_next = 1'b0;
                char_next       = CH_SPACE;
                inv_next        = 1'b0;
                last_next       = 1'b1;
            end
            else if (head.valid && head.entry.has_letter)
            begin
                // hold the space for the next transfer
                valid_next      = 1'b1;
                space_pend_next = head.entry.has_space;
                char_next       = lk.ch;
                inv_next        = lk.inv;
                last_next       = !head.entry.has_space;
            end
            else if (head.valid)
            begin
                valid_next = 1'b1;
                char_next  = CH_SPACE;
                inv_next   = 1'b0;
                last_next  = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            space_pend_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            space_pend_reg <= space_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        inv_reg  <= inv_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign char_code   = char_reg;
    assign is_invalid  = inv_reg;
    assign last_of_run = last_reg;

    a_pend_after_letter: assert property (@(posedge clk) disable iff (!rst_n)
        space_pend_reg |-> (valid_reg && !last_reg && char_reg != CH_SPACE))
        else $error("pending space without a letter in front of it");

    a_space_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && char_reg == CH_SPACE) |-> (last_reg && !inv_reg))
        else $error("space result not last of run");

    a_invalid_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && inv_reg) |-> (char_reg == CH_INVALID))
        else $error("invalid flag without error mark");

endmodule

// ===== hdl/morse_key_timing_decoder.sv =====
// Morse key timing decoder, top level: configuration registers, front end,
// action queue and back end. Depends on mktd_pkg, mktd_front, mktd_fifo, mktd_back.
//
// Usage:
//   Input channel (in_valid/in_stall, key_level): one transfer per key tick.
//   Output channel (out_valid/out_stall, char_code/is_invalid/last_of_run):
//   decoded letters 'A'..'Z', '#' with is_invalid for an unknown code, and ' '
//   for a word space. last_of_run marks the final result caused by one tick.
//   Configuration: cfg_wr_en writes cfg_wdata into the dash threshold (index 0)
//   or the word-space gap (index 1); write only while the block is idle.
// Throughput: one tick per cycle while in_stall is low. A tick with two results (letter then
//   space) occupies the output register for two transfers; the 4-entry action
//   queue between front and back end absorbs this.
// Path: with an empty queue and a free output register, the tick's transfer writes
//   its action into the queue; the back end then moves it to the output register.
// Stall: when the receiver stalls, the output holds and the queue fills;
//   in_stall rises once the queue holds four actions. Ticks with no result
//   never occupy the queue.
// Reset: all timing state, the code register and the queue are cleared;
//   the dash threshold returns to 500 and the word-space gap to 1250.
module morse_key_timing_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [mktd_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          key_level,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mktd_pkg::CHAR_W-1:0]   char_code,
    output logic                          is_invalid,
    output logic                          last_of_run
);
    import mktd_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   full;
    logic   accept;
    logic   push;
    logic   pop;
    entry_t push_entry;
    head_t  head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DASH_MIN:  cfg_next.dash_min  = cfg_wdata;
                REG_SPACE_GAP: cfg_next.space_gap = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dash_min  <= DASH_MIN_RESET;
            cfg_reg.space_gap <= SPACE_GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall = full;
    assign accept   = in_valid && !full;

    mktd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .key_level  (key_level),
        .push       (push),
        .push_entry (push_entry)
    );

    mktd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head       (head)
    );

    mktd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .is_invalid  (is_invalid),
        .last_of_run (last_of_run)
    );

endmodule

// ===== tb/tb_morse_key_timing_decoder.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for morse_key_timing_decoder: streams key ticks, predicts the decoded
// letters and spaces, and checks every output transfer. Depends on mktd_pkg and the RTL.
module tb_morse_key_timing_decoder;

    import mktd_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    // well above the longest output hold-off plus random stalls
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              inv;
        logic              last;
    } decoded_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              key_level = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CHAR_W-1:0] char_code;
    logic              is_invalid;
    logic              last_of_run;

    logic     key_ticks[$];
    decoded_t expected_chars[$];
    decoded_t tick_chars[$];
    decoded_t head_char;
    int       send_idle_pct = 31;
    int       recv_idle_pct = 31;
    logic     hold_arm = 1'b0;
    logic     hold_done = 1'b0;
    int       hold_left = 0;
    int       quiet_cycles = 0;
    int       mismatches = 0;

    // decoder state as predicted
    logic [CFG_W-1:0]       dash_len = DASH_MIN_RESET;
    logic [CFG_W-1:0]       space_len = SPACE_GAP_RESET;
    logic                   prev_key = 1'b0;
    logic [COUNT_WIDTH-1:0] tick_count = '0;
    logic [7:0]             sym_code = '0;
    logic [2:0]             sym_count = '0;

    morse_key_timing_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key_level   (key_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .is_invalid  (is_invalid),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] morse_ascii(input logic [7:0] code);
        case (code)
            8'h60: return "A";
            8'h95: return "B";
            8'h99: return "C";
            8'h94: return "D";
            8'h40: return "E";
            8'h59: return "F";
            8'hA4: return "G";
            8'h55: return "H";
            8'h50: return "I";
            8'h6A: return "J";
            8'h98: return "K";
            8'h65: return "L";
            8'hA0: return "M";
            8'h90: return "N";
            8'hA8: return "O";
            8'h69: return "P";
            8'hA6: return "Q";
            8'h64: return "R";
            8'h54: return "S";
            8'h80: return "T";
            8'h58: return "U";
            8'h56: return "V";
            8'h68: return "W";
            8'h96: return "X";
            8'h9A: return "Y";
            8'hA5: return "Z";
            default: return 8'd0;
        endcase
    endfunction

    task automatic close_letter;
        logic [7:0] ascii;
        if (sym_count != 3'd0)
        begin
            ascii = morse_ascii(sym_code);
            if (ascii == 8'd0)
                tick_chars.push_back(decoded_t'{ch: CH_INVALID, inv: 1'b1, last: 1'b0});
            else
                tick_chars.push_back(decoded_t'{ch: ascii[CHAR_W-1:0], inv: 1'b0, last: 1'b0});
            sym_code  = '0;
            sym_count = '0;
        end
    endtask

    task automatic add_symbol(input logic [1:0] sym);
        if (sym_count >= 3'd4)
            close_letter();
        sym_code  = sym_code | ({6'd0, sym} << (6 - 2 * int'(sym_count)));
        sym_count = sym_count + 3'd1;
        if (sym_count >= 3'd4)
            close_letter();
    endtask

    // Advance the decoder state by one tick and queue the results it causes.
    task automatic predict_tick(input logic lvl);
        logic [COUNT_WIDTH-1:0] cnt;
        decoded_t               tail;
        tick_chars.delete();
        cnt = tick_count;
        if (cnt != '1)
            cnt = cnt + 1'b1;
        if (prev_key && !lvl)
        begin
            add_symbol((cnt >= dash_len) ? SYM_DASH : SYM_DOT);
            tick_count = '0;
        end
        else if (!prev_key && lvl)
        begin
            if (cnt >= dash_len && cnt < space_len)
                close_letter();
            tick_count = '0;
        end
        else
        begin
            // fire once, on the tick the released gap first reaches the space gap
            if (!lvl && cnt == space_len && cnt != tick_count)
            begin
                close_letter();
                tick_chars.push_back(decoded_t'{ch: CH_SPACE, inv: 1'b0, last: 1'b0});
            end
            tick_count = cnt;
        end
        prev_key = lvl;
        if (tick_chars.size() > 0)
        begin
            tail = tick_chars.pop_back();
            tail.last = 1'b1;
            tick_chars.push_back(tail);
        end
        while (tick_chars.size() > 0)
            expected_chars.push_back(tick_chars.pop_front());
    endtask

    function automatic int press_len(input logic dash);
        int lo;
        lo = (dash_len > 0) ? int'(dash_len) : 1;
        if (!dash && dash_len > 1)
            return $urandom_range(1, int'(dash_len) - 1);
        return $urandom_range(lo, lo + 3);
    endfunction

    function automatic int short_gap();
        if (dash_len > 1)
            return $urandom_range(1, int'(dash_len) - 1);
        return 1;
    endfunction

    function automatic int letter_gap();
        int lo;
        int hi;
        lo = (dash_len > 0) ? int'(dash_len) : 1;
        hi = (int'(space_len) > lo) ? int'(space_len) - 1 : lo;
        if (hi > lo + 12)
            hi = lo + 12;
        return $urandom_range(lo, hi);
    endfunction

    function automatic int word_gap();
        return int'(space_len) + $urandom_range(1, 6);
    endfunction

    task automatic push_run(input logic lvl, input int n);
        repeat (n) key_ticks.push_back(lvl);
    endtask

    task automatic push_press(input int len, input int gap);
        push_run(1'b1, len);
        push_run(1'b0, gap);
    endtask

    // Symbol i of the letter is a dash when dashes[i] is set.
    task automatic push_letter(input int nsym, input logic [4:0] dashes, input int end_gap);
        for (int i = 0; i < nsym; i++)
            push_press(press_len(dashes[i]), (i == nsym - 1) ? end_gap : short_gap());
    endtask

    task automatic push_random_traffic(input int n);
        int target;
        int pick;
        int gap;
        target = key_ticks.size() + n;
        while (key_ticks.size() < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                if (pick < 20 && space_len <= 64)
                    gap = word_gap();
                else if (pick < 55)
                    gap = letter_gap();
                else
                    gap = short_gap();
                push_letter($urandom_range(1, 5), 5'($urandom), gap);
            end
            else
            begin
                // noise: short random runs of either level
                repeat ($urandom_range(1, 6))
                    push_run($urandom_range(1) == 1, $urandom_range(1, 3));
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DASH_MIN)
            dash_len = val;
        else
            space_len = val;
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] dash, input logic [CFG_W-1:0] space);
        write_reg(REG_DASH_MIN, dash);
        write_reg(REG_SPACE_GAP, space);
        @(negedge clk);
    endtask

    // Wait for every tick to be sent and every result to arrive, then let the pipe settle.
    task automatic wait_drained;
        do
            @(negedge clk);
        while (key_ticks.size() != 0 || in_valid || expected_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // key tick sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_tick(key_level);
            if (!in_valid || !in_stall)
            begin
                if (key_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    key_level <= key_ticks.pop_front();
                end
                else
                begin
                    in_valid  <= 1'b0;
                    key_level <= ($urandom_range(1) == 1);
                end
            end
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected nothing, got char %0d inv %0b last %0b",
                             $time, char_code, is_invalid, last_of_run);
                end
                else
                begin
                    head_char = expected_chars.pop_front();
                    if (char_code !== head_char.ch || is_invalid !== head_char.inv
                        || last_of_run !== head_char.last)
                    begin
                        mismatches++;
                        $display("%0t: expected char %0d inv %0b last %0b, got char %0d inv %0b last %0b",
                                 $time, head_char.ch, head_char.inv, head_char.last,
                                 char_code, is_invalid, last_of_run);
                    end
                end
            end
            if (hold_arm && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog: count cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("morse_key_timing_decoder verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_timing(16'd3, 16'd8);
        // four dots close the letter on the last release; the next gap holds nothing
        push_press(1, 1);
        push_press(1, 1);
        push_press(2, 1);
        push_press(2, 4);
        // four dashes match no letter; a fifth opens a new one, flushed ahead of a space
        repeat (4) push_press(3, 1);
        push_press(3, 9);
        // a press as long as the space gap is only a dash
        push_press(8, 1);
        push_press(2, 4);
        // invalid code, then a space with nothing pending
        push_press(1, 1);
        push_press(1, 1);
        push_press(3, 1);
        push_press(3, 12);
        for (int n = 1; n <= 4; n++)
            for (int p = 0; p < (1 << n); p++)
                push_letter(n, 5'(p), letter_gap());
        push_random_traffic(60);
        wait_drained();

        // dense results; hold the output off so the action queue fills and stalls the input
        set_timing(16'd1, 16'd2);
        push_random_traffic(100);
        hold_arm = 1'b1;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timing(16'd2, 16'd6);
        push_random_traffic(100);
        wait_drained();
        send_idle_pct = 31;
        recv_idle_pct = 31;

        // zero timing: every press a dash, no space ever
        set_timing(16'd0, 16'd0);
        push_random_traffic(30);
        wait_drained();

        set_timing(16'd7, 16'd3);
        push_random_traffic(40);
        wait_drained();

        set_timing(16'd1, 16'hFFFF);
        push_random_traffic(30);
        wait_drained();

        if (mismatches == 0 && expected_chars.size() == 0)
            $display("morse_key_timing_decoder verification clean");
        else
            $display("morse_key_timing_decoder verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mktd_pkg.sv
hdl/mktd_front.sv
hdl/mktd_fifo.sv
hdl/mktd_back.sv
hdl/morse_key_timing_decoder.sv
tb/tb_morse_key_timing_decoder.sv
